[src/assert_macros.svh]
// Assertion macros used by the port checker.
// Depends on a clk and rst_n being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check clocked on clk, off during reset.
`define KDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold.
`define KDT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/kdt_pkg.sv]
// Package for the kd-tree insert and radius search block.
// Holds sizes, status codes, state type and coordinate helpers; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kdt_pkg;
  localparam int TREE_LEVELS = 6;
  localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
  localparam int NODE_W      = 6;
  localparam int LVL_W       = 3;
  localparam int COORD_W     = 16;
  localparam int NODE_DATA_W = 96;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 104;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_END      = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_R2     = 10'b00_0000_0010,
    S_VISIT  = 10'b00_0000_0100,
    S_INSCMP = 10'b00_0000_1000,
    S_PLANE  = 10'b00_0001_0000,
    S_RESUME = 10'b00_0010_0000,
    S_DIST   = 10'b00_0100_0000,
    S_MATCH  = 10'b00_1000_0000,
    S_END    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  function automatic logic [COORD_W-1:0] coord_sel(input logic [3*COORD_W-1:0] v,
                                                   input logic [1:0] a);
    logic [COORD_W-1:0] r;
    case (a)
      AX_X:    r = v[COORD_W-1:0];
      AX_Y:    r = v[2*COORD_W-1:COORD_W];
      default: r = v[3*COORD_W-1:2*COORD_W];
    endcase
    return r;
  endfunction

  function automatic logic [1:0] ax_inc(input logic [1:0] a);
    return (a == AX_Z) ? AX_X : a + 2'd1;
  endfunction

  function automatic logic [1:0] ax_dec(input logic [1:0] a);
    return (a == AX_X) ? AX_Z : a - 2'd1;
  endfunction
endpackage
`default_nettype wire

[src/kdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/kd_tree_insert_radius_search.sv]
// kd-tree insert and radius search over a 63-node heap-ordered 3-D tree.
// Depends on kdt_pkg and kdt_ram.
//
// Usage:
//  - Input channel in_*: in_tuser is mode (0 insert, 1 search); in_tdata carries
//    position, radius and power. One transaction is one item.
//  - Result channel out_*: in_tuser's counterpart out_tuser is the status,
//    out_tlast marks the last result of an item.
//  - Insert: walks root to leaf through S_VISIT and S_INSCMP at each filled
//    level, one result.
//  - Search: depth-first, post-order. One shared 16x16 squarer serves the
//    radius square, plane tests and the three-axis distance sum. Each filled
//    node is scored in S_DIST and S_MATCH after its children. Results come
//    out as matches then an end marker.
//  - in_tready is high only while idle; one item is worked at a time.
//  - A stalled receiver holds the output register and freezes the walk
//    at the next result; nothing is dropped.
//  - Reset (rst_n low, synchronous) empties every node at once through
//    per-node valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module kd_tree_insert_radius_search
  import kdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] radius,
  // [79:64] power_r, [95:80] power_g, [111:96] power_b
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [5:0] node_index, [21:6] found_x, [37:22] found_y, [53:38] found_z,
  // [69:54] found_r, [85:70] found_g, [101:86] found_b, [103:102] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [1:0] status
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);
  state_t state_r, state_nxt;

  // Item registers
  logic                     mode_r;
  logic [3*COORD_W-1:0]     ctr_r;
  logic [COORD_W-1:0]       rad_r;
  logic [3*COORD_W-1:0]     pwr_r;
  logic [2*COORD_W-1:0]     r2_r;

  // Walk stack, one frame per level
  logic [LVL_W-1:0]         lvl_r;
  logic [1:0]               ax_r;
  logic [1:0]               dax_r;
  logic [2*COORD_W+1:0]     acc_r;
  logic [NODE_W-1:0]        stk_idx_r [TREE_LEVELS];
  logic                     stk_ph_r  [TREE_LEVELS];
  logic                     stk_far_r [TREE_LEVELS];
  logic                     stk_neg_r [TREE_LEVELS];
  logic [NODE_COUNT-1:0]    vld_r;

  // Output register
  logic                     ov_r;
  logic [OUT_DATA_W-1:0]    od_r;
  logic [1:0]               ou_r;
  logic                     ol_r;

  logic [NODE_DATA_W-1:0]   ram_q;
  logic                     ram_we;
  logic [NODE_W-1:0]        cur_idx;
  logic                     cur_vld;
  logic                     out_free;
  logic                     last_lvl;
  logic                     in_acc;

  // Shared arithmetic unit
  logic [1:0]               sel_ax;
  logic [COORD_W-1:0]       cq, nq;
  logic [COORD_W:0]         diff, absd;
  logic [COORD_W-1:0]       mul_a;
  logic [2*COORD_W-1:0]     prod;
  logic [2*COORD_W+1:0]     acc_sum;

  // Result load
  logic                     o_load;
  logic [1:0]               o_stat;
  logic [NODE_W-1:0]        o_idx;
  logic                     o_node;
  logic                     o_last;

  // Stack control
  logic                     push;
  logic [NODE_W-1:0]        push_idx;
  logic                     pop;

  logic [NODE_W-1:0]        lchild, rchild;

  assign cur_idx  = stk_idx_r[lvl_r];
  assign cur_vld  = vld_r[cur_idx];
  assign out_free = !ov_r || out_tready;
  assign last_lvl = (lvl_r == LVL_W'(TREE_LEVELS - 1));
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign lchild   = {cur_idx[NODE_W-2:0], 1'b1};
  assign rchild   = {cur_idx[NODE_W-2:0], 1'b0} + NODE_W'(2);

  assign sel_ax  = (state_r == S_DIST) ? dax_r : ax_r;
  assign cq      = coord_sel(ctr_r, sel_ax);
  assign nq      = coord_sel(ram_q[3*COORD_W-1:0], sel_ax);
  assign diff    = {cq[COORD_W-1], cq} - {nq[COORD_W-1], nq};
  assign absd    = diff[COORD_W] ? (~diff + 1'b1) : diff;
  assign mul_a   = (state_r == S_R2) ? rad_r : absd[COORD_W-1:0];
  assign prod    = mul_a * mul_a;
  assign acc_sum = acc_r + {2'b00, prod};

  assign ram_we = (state_r == S_VISIT) && (mode_r == MODE_INSERT) && !cur_vld && out_free;

  kdt_ram #(.WIDTH(NODE_DATA_W), .DEPTH(NODE_COUNT)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_idx),
    .wdata ({pwr_r, ctr_r}),
    .raddr (cur_idx),
    .rdata (ram_q)
  );

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    push_idx  = lchild;
    pop       = 1'b0;
    o_load    = 1'b0;
    o_stat    = ST_END;
    o_idx     = '0;
    o_node    = 1'b0;
    o_last    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == MODE_SEARCH) ? S_R2 : S_VISIT;
        end
      end
      S_R2: state_nxt = S_VISIT;
      S_VISIT: begin
        if (!cur_vld) begin
          if (mode_r == MODE_INSERT) begin
            // Store in the first empty node and report it.
            if (out_free) begin
              o_load    = 1'b1;
              o_stat    = ST_INSERTED;
              o_idx     = cur_idx;
              state_nxt = S_IDLE;
            end
          end else begin
            pop = 1'b1;
          end
        end else if (last_lvl) begin
          if (mode_r == MODE_INSERT) begin
            if (out_free) begin
              o_load    = 1'b1;
              o_stat    = ST_FULL;
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_DIST;
          end
        end else begin
          state_nxt = (mode_r == MODE_INSERT) ? S_INSCMP : S_PLANE;
        end
      end
      S_INSCMP: begin
        push      = 1'b1;
        push_idx  = diff[COORD_W] ? lchild : rchild;
        state_nxt = S_VISIT;
      end
      S_PLANE: begin
        // Near child first.
        push      = 1'b1;
        push_idx  = diff[COORD_W] ? lchild : rchild;
        state_nxt = S_VISIT;
      end
      S_RESUME: begin
        if (!stk_ph_r[lvl_r] && stk_far_r[lvl_r]) begin
          push      = 1'b1;
          push_idx  = stk_neg_r[lvl_r] ? rchild : lchild;
          state_nxt = S_VISIT;
        end else begin
          state_nxt = S_DIST;
        end
      end
      S_DIST: begin
        if (dax_r == AX_Z) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        if (acc_r < {2'b00, r2_r}) begin
          if (out_free) begin
            o_load = 1'b1;
            o_stat = ST_MATCH;
            o_idx  = cur_idx;
            o_node = 1'b1;
            o_last = 1'b0;
            pop    = 1'b1;
          end
        end else begin
          pop = 1'b1;
        end
      end
      S_END: begin
        if (out_free) begin
          o_load    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (pop) begin
      state_nxt = (lvl_r == '0) ? S_END : S_RESUME;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
      lvl_r   <= '0;
      ax_r    <= AX_X;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[cur_idx] <= 1'b1;
      end
      if (o_load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (in_acc) begin
        lvl_r <= '0;
        ax_r  <= AX_X;
      end else if (push) begin
        lvl_r <= lvl_r + LVL_W'(1);
        ax_r  <= ax_inc(ax_r);
      end else if (pop && lvl_r != '0) begin
        lvl_r <= lvl_r - LVL_W'(1);
        ax_r  <= ax_dec(ax_r);
      end
    end
  end

  // Datapath and stack frames
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r       <= in_tuser;
      ctr_r        <= in_tdata[3*COORD_W-1:0];
      rad_r        <= in_tdata[4*COORD_W-1:3*COORD_W];
      pwr_r        <= in_tdata[7*COORD_W-1:4*COORD_W];
      stk_idx_r[0] <= '0;
    end
    if (state_r == S_R2) begin
      r2_r <= prod;
    end
    if (state_r == S_PLANE) begin
      stk_ph_r[lvl_r]  <= 1'b0;
      stk_neg_r[lvl_r] <= diff[COORD_W];
      stk_far_r[lvl_r] <= prod < r2_r;
    end
    if (state_r == S_RESUME && push) begin
      stk_ph_r[lvl_r] <= 1'b1;
    end
    if (push) begin
      stk_idx_r[lvl_r + LVL_W'(1)] <= push_idx;
    end
    if (state_r == S_DIST) begin
      acc_r <= acc_sum;
      dax_r <= ax_inc(dax_r);
    end else begin
      acc_r <= '0;
      dax_r <= AX_X;
    end
    if (o_load) begin
      // Zero pad on top, node payload only for a match.
      od_r <= {{(OUT_DATA_W - NODE_W - NODE_DATA_W){1'b0}},
               (o_node ? ram_q : {NODE_DATA_W{1'b0}}), o_idx};
      ou_r <= o_stat;
      ol_r <= o_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;
endmodule
`default_nettype wire

[src/kdt_checker.sv]
// Port-level checker for the kd-tree block, bound to the top level.
// Depends on kdt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kdt_port_checker
  import kdt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]            out_tuser,
  input wire logic                  out_tlast
);
  `KDT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `KDT_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")
  `KDT_ASSERT(a_match_not_last, out_tvalid && out_tuser == ST_MATCH |-> !out_tlast, "match marked last")
  `KDT_ASSERT(a_end_last, out_tvalid && (out_tuser == ST_END || out_tuser == ST_FULL) |-> out_tlast && out_tdata[NODE_W-1:0] == '0, "bad end or full result")
endmodule

bind kd_tree_insert_radius_search kdt_port_checker u_kdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
